// ----- hw/rtl/rlts_pkg.sv -----
// Shared types and constants of the random LED twinkle scheduler.
package rlts_pkg;

    localparam int DATA_W   = 32;
    localparam int SLOT_W   = 3;
    localparam int LED_W    = 3;
    localparam int CHAN_W   = 4;
    localparam int CNT_W    = 4;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [CHAN_W-1:0] CHANNEL_BASE = 4'd3;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_SERVICE = 1'b1;

    localparam logic [DATA_W-1:0] RST_START_OFFSET_MAX = 32'd2000;
    localparam logic [DATA_W-1:0] RST_PERIOD_MIN       = 32'd500;
    localparam logic [DATA_W-1:0] RST_PERIOD_MAX       = 32'd3000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_OFFSET_MAX = 2'd0,
        REG_PERIOD_MIN       = 2'd1,
        REG_PERIOD_MAX       = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_RUN   = 2'd1,
        ST_SWAP  = 2'd2,
        ST_START = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_OFF   = 6'b000100,
        S_PICK  = 6'b001000,
        S_PER   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] now_ms;
        logic [DATA_W-1:0] rand_offset;
        logic [DATA_W-1:0] rand_pick;
        logic [DATA_W-1:0] rand_period;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_out;
        logic [LED_W-1:0]  old_led;
        logic [LED_W-1:0]  new_led;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] start_time;
        logic [DATA_W-1:0] period;
    } t_out_item;

endpackage

// ----- hw/rtl/rlts_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transaction.
interface rlts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/random_led_twinkle_scheduler_top.sv -----
// Random LED twinkle scheduler: slot table, free LED mask and a shared serial remainder unit.
//
//  channel   direction  protocol        payload
//  i_in      in         valid/ready     rlts_pkg::t_in_item (func, slot, now_ms, rand_*)
//  o_out     out        valid/ready     rlts_pkg::t_out_item (status, slot_out, leds, ...)
//  apb       in/out     APB, pready=1   start_offset_max 0x0, period_min 0x4, period_max 0x8
//
// One bit-per-cycle remainder unit does every modulo in turn. A start item runs the offset and
// LED pick, a swap the offset, pick and period, and a waiting, running or ignored item none of
// them; the input is not ready while an item is in work.
// A finished result sits in the output register, so the next item is taken while it waits.
// Reset is synchronous and active low; it clears the control state and frees all LEDs.
module random_led_twinkle_scheduler_top #(
    parameter int NUM_SLOTS = 3,
    parameter int NUM_LEDS  = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rlts_stream_if.sink                   i_in,
    rlts_stream_if.source                 o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlts_pkg::PADDR_W-1:0]  paddr,
    input  logic [rlts_pkg::DATA_W-1:0]   pwdata,
    output logic [rlts_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DW  = rlts_pkg::DATA_W;
    localparam int LW  = rlts_pkg::LED_W;
    localparam int CW  = rlts_pkg::CNT_W;
    localparam int STEP_W = $clog2(DW);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DW - 1);
    localparam logic [NUM_LEDS-1:0] LED_ALL = '1;
    localparam logic [rlts_pkg::SLOT_W-1:0] SLOT_LIMIT = NUM_SLOTS[rlts_pkg::SLOT_W-1:0];

    // Configuration registers.
    logic [DW-1:0] r_som, r_pmin, r_pmax;

    // Sequencer and the item in work.
    rlts_pkg::t_state   r_state, n_state;
    rlts_pkg::t_in_item r_item;
    rlts_pkg::t_status  r_status, w_check_status;
    logic               r_slot_ok, w_slot_ok;

    // Slot table and free mask.
    logic [DW-1:0]       r_start  [NUM_SLOTS];
    logic [DW-1:0]       r_period [NUM_SLOTS];
    logic [LW-1:0]       r_led    [NUM_SLOTS];
    logic [NUM_LEDS-1:0] r_mask, w_mask_next;

    // Shared remainder unit.
    logic [DW-1:0]     r_rem, r_dvd, r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              n_load;
    logic [DW-1:0]     n_dvd, n_div;
    logic [DW:0]       w_trial;
    logic              w_ge;
    logic [DW-1:0]     w_rem_next;
    logic              w_div_busy;

    // Captured remainders.
    logic [DW-1:0] r_off, r_per_rem;
    logic [LW-1:0] r_k;

    // Output register.
    logic                r_out_valid;
    rlts_pkg::t_out_item r_out, w_out;
    logic                w_commit;

    // Slot lookup and LED selection.
    logic [SIW-1:0]      w_idx;
    logic [DW-1:0]       w_cur_start, w_cur_period;
    logic [LW-1:0]       w_cur_led;
    logic [DW:0]         w_end;
    logic [NUM_LEDS-1:0] w_pick_mask, w_sel_oh, w_cur_oh;
    logic [CW-1:0]       w_count, w_seen;
    logic [LW-1:0]       w_sel_led, w_led;
    logic                w_have, w_found;
    logic [DW-1:0]       w_off, w_new_start, w_new_per;
    logic                w_accept;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == rlts_pkg::S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign pready = 1'b1;

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_som  <= rlts_pkg::RST_START_OFFSET_MAX;
            r_pmin <= rlts_pkg::RST_PERIOD_MIN;
            r_pmax <= rlts_pkg::RST_PERIOD_MAX;
        end else if (psel && penable && pwrite) begin
            unique case (rlts_pkg::t_reg_idx'(paddr[rlts_pkg::PADDR_W-1:2]))
                rlts_pkg::REG_START_OFFSET_MAX: r_som  <= pwdata;
                rlts_pkg::REG_PERIOD_MIN:       r_pmin <= pwdata;
                rlts_pkg::REG_PERIOD_MAX:       r_pmax <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rlts_pkg::t_reg_idx'(paddr[rlts_pkg::PADDR_W-1:2]))
            rlts_pkg::REG_START_OFFSET_MAX: prdata = r_som;
            rlts_pkg::REG_PERIOD_MIN:       prdata = r_pmin;
            rlts_pkg::REG_PERIOD_MAX:       prdata = r_pmax;
            default:                        prdata = '0;
        endcase
    end

    // Slot lookup and classification.
    assign w_idx        = r_item.slot[SIW-1:0];
    assign w_cur_start  = r_start[w_idx];
    assign w_cur_period = r_period[w_idx];
    assign w_cur_led    = r_led[w_idx];
    assign w_end        = {1'b0, w_cur_start} + {1'b0, w_cur_period};
    assign w_slot_ok    = (r_item.slot < SLOT_LIMIT);

    always_comb begin
        priority if (!w_slot_ok) begin
            w_check_status = rlts_pkg::ST_WAIT;
        end else if (r_item.func == rlts_pkg::FUNC_START) begin
            w_check_status = rlts_pkg::ST_START;
        end else if (w_cur_start > r_item.now_ms) begin
            w_check_status = rlts_pkg::ST_WAIT;
        end else if (w_end < {1'b0, r_item.now_ms}) begin
            w_check_status = rlts_pkg::ST_SWAP;
        end else begin
            w_check_status = rlts_pkg::ST_RUN;
        end
    end

    // A start item on slot 0 picks from a fully refilled mask.
    assign w_pick_mask = (r_item.func == rlts_pkg::FUNC_START && r_item.slot == '0) ?
                         LED_ALL : r_mask;

    always_comb begin
        w_count = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            w_count = w_count + {{(CW-1){1'b0}}, w_pick_mask[i]};
        end
    end

    // Walk the free LEDs upward and stop at the k-th one.
    always_comb begin
        w_seen    = '0;
        w_found   = 1'b0;
        w_sel_led = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            if (w_pick_mask[i]) begin
                if (!w_found && w_seen == {1'b0, r_k}) begin
                    w_sel_led = i[LW-1:0];
                    w_found   = 1'b1;
                end
                w_seen = w_seen + CW'(1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            w_sel_oh[i] = (w_sel_led == i[LW-1:0]);
            w_cur_oh[i] = (w_cur_led == i[LW-1:0]);
        end
    end

    assign w_have      = (w_count != '0);
    assign w_off       = (r_som == '0) ? '0 : r_off;
    assign w_new_start = r_item.now_ms + w_off;
    assign w_new_per   = (r_pmax <= r_pmin) ? r_pmin : r_pmin + r_per_rem;

    // Result and the state that a commit leaves behind.
    always_comb begin
        w_led       = w_cur_led;
        w_mask_next = r_mask;
        w_out.status     = r_status;
        w_out.slot_out   = r_item.slot;
        w_out.channel    = {1'b0, r_item.slot} + rlts_pkg::CHANNEL_BASE;
        w_out.old_led    = w_cur_led;
        w_out.new_led    = w_cur_led;
        w_out.start_time = w_cur_start;
        w_out.period     = w_cur_period;
        if (!r_slot_ok) begin
            w_out.old_led    = '0;
            w_out.new_led    = '0;
            w_out.start_time = '0;
            w_out.period     = '0;
        end else if (r_status == rlts_pkg::ST_START) begin
            w_led       = w_have ? w_sel_led : '0;
            w_mask_next = w_have ? (w_pick_mask & ~w_sel_oh) : w_pick_mask;
            w_out.old_led    = w_led;
            w_out.new_led    = w_led;
            w_out.start_time = w_new_start;
            w_out.period     = '0;
        end else if (r_status == rlts_pkg::ST_SWAP) begin
            w_led       = w_have ? w_sel_led : w_cur_led;
            w_mask_next = w_have ? ((r_mask | w_cur_oh) & ~w_sel_oh) : r_mask;
            w_out.new_led    = w_led;
            w_out.start_time = w_new_start;
            w_out.period     = w_new_per;
        end
    end

    // Serial restoring remainder step.
    assign w_trial    = {r_rem, r_dvd[DW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_rem_next = w_ge ? DW'(w_trial - {1'b0, r_div}) : w_trial[DW-1:0];
    assign w_div_busy = (r_state == rlts_pkg::S_OFF) || (r_state == rlts_pkg::S_PICK) ||
                        (r_state == rlts_pkg::S_PER);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_load   = 1'b0;
        n_dvd    = '0;
        n_div    = '0;
        w_commit = 1'b0;
        unique case (r_state)
            rlts_pkg::S_IDLE: begin
                if (i_in.valid) n_state = rlts_pkg::S_CHECK;
            end
            rlts_pkg::S_CHECK: begin
                if (w_check_status == rlts_pkg::ST_START ||
                    w_check_status == rlts_pkg::ST_SWAP) begin
                    n_state = rlts_pkg::S_OFF;
                    n_load  = 1'b1;
                    n_dvd   = r_item.rand_offset;
                    n_div   = r_som;
                end else begin
                    n_state = rlts_pkg::S_DONE;
                end
            end
            rlts_pkg::S_OFF: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = rlts_pkg::S_PICK;
                    n_load  = 1'b1;
                    n_dvd   = r_item.rand_pick;
                    n_div   = {{(DW-CW){1'b0}}, w_count};
                end
            end
            rlts_pkg::S_PICK: begin
                if (r_cnt == DIV_LAST) begin
                    if (r_status == rlts_pkg::ST_SWAP) begin
                        n_state = rlts_pkg::S_PER;
                        n_load  = 1'b1;
                        n_dvd   = r_item.rand_period;
                        n_div   = r_pmax - r_pmin;
                    end else begin
                        n_state = rlts_pkg::S_DONE;
                    end
                end
            end
            rlts_pkg::S_PER: begin
                if (r_cnt == DIV_LAST) n_state = rlts_pkg::S_DONE;
            end
            rlts_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state  = rlts_pkg::S_IDLE;
                    w_commit = 1'b1;
                end
            end
            default: n_state = rlts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_mask      <= LED_ALL;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (n_load) begin
                r_cnt <= '0;
            end else if (w_div_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if (r_slot_ok) r_mask <= w_mask_next;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_in.data;
        if (r_state == rlts_pkg::S_CHECK) begin
            r_status  <= w_check_status;
            r_slot_ok <= w_slot_ok;
        end
        if (n_load) begin
            r_rem <= '0;
            r_dvd <= n_dvd;
            r_div <= n_div;
        end else if (w_div_busy) begin
            r_rem <= w_rem_next;
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
        end
        if (w_div_busy && r_cnt == DIV_LAST) begin
            if (r_state == rlts_pkg::S_OFF)  r_off     <= w_rem_next;
            if (r_state == rlts_pkg::S_PICK) r_k       <= w_rem_next[LW-1:0];
            if (r_state == rlts_pkg::S_PER)  r_per_rem <= w_rem_next;
        end
        if (w_commit) begin
            r_out <= w_out;
            if (r_slot_ok && (r_status == rlts_pkg::ST_START ||
                              r_status == rlts_pkg::ST_SWAP)) begin
                r_start[w_idx]  <= w_out.start_time;
                r_period[w_idx] <= w_out.period;
                r_led[w_idx]    <= w_led;
            end
        end
    end

    // An accepted transaction always goes to slot classification first.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rlts_pkg::S_CHECK))
        else $error("accepted transaction did not enter classification");

    // The partial remainder never reaches a nonzero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_busy && r_div != '0) |-> (r_rem < r_div))
        else $error("remainder unit out of range");

    // A finished item is presented on the output in the next cycle.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlts_pkg::S_DONE && (!r_out_valid || o_out.ready)) |=>
        (o_out.valid && r_state == rlts_pkg::S_IDLE))
        else $error("finished item not delivered");

    // A started slot reports one LED and no period.
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == rlts_pkg::ST_START) |->
        (o_out.data.period == '0 && o_out.data.old_led == o_out.data.new_led))
        else $error("start result inconsistent");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench of the random LED twinkle scheduler: directed and random traffic.
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_SLOTS    = 3;
    localparam int NUM_LEDS     = 7;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_REPORTS  = 10;
    localparam int DATA_W       = rlts_pkg::DATA_W;
    localparam int PADDR_W      = rlts_pkg::PADDR_W;
    localparam int SLOT_W       = rlts_pkg::SLOT_W;
    localparam int LED_W        = rlts_pkg::LED_W;
    localparam int CHAN_W       = rlts_pkg::CHAN_W;
    localparam logic [NUM_LEDS-1:0] ALL_LEDS = '1;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    rlts_stream_if #(.T(rlts_pkg::t_in_item))  in_ch ();
    rlts_stream_if #(.T(rlts_pkg::t_out_item)) out_ch ();

    random_led_twinkle_scheduler_top #(
        .NUM_SLOTS(NUM_SLOTS),
        .NUM_LEDS (NUM_LEDS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #10 i_clk = ~i_clk;

    // Scheduler state as the testbench predicts it.
    logic [DATA_W-1:0]   offset_bound;
    logic [DATA_W-1:0]   period_floor;
    logic [DATA_W-1:0]   period_ceil;
    logic [DATA_W-1:0]   slot_begin [NUM_SLOTS];
    logic [DATA_W-1:0]   slot_len   [NUM_SLOTS];
    logic [LED_W-1:0]    slot_owner [NUM_SLOTS];
    logic [NUM_LEDS-1:0] leds_free;
    bit                  slot_armed [NUM_SLOTS];

    rlts_pkg::t_out_item twinkle_expected [$];

    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned ignored_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned settings_applied = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;

    function automatic logic [DATA_W-1:0] delay_of(logic [DATA_W-1:0] r);
        return (offset_bound == '0) ? '0 : r % offset_bound;
    endfunction

    function automatic logic [DATA_W-1:0] breathe_of(logic [DATA_W-1:0] r);
        return (period_ceil <= period_floor) ? period_floor
                                             : period_floor + r % (period_ceil - period_floor);
    endfunction

    // The pick selects the (r mod count)-th free LED, counting upward from LED 0.
    function automatic bit choose_free_led(logic [DATA_W-1:0] r, output logic [LED_W-1:0] led);
        int unsigned count;
        int unsigned k;
        int i;
        led = '0;
        count = $countones(leds_free);
        if (count == 0) return 1'b0;
        k = r % count;
        for (i = 0; i < NUM_LEDS; i++) begin
            if (leds_free[i]) begin
                if (k == 0) begin
                    led = LED_W'(i);
                    return 1'b1;
                end
                k--;
            end
        end
        return 1'b0;
    endfunction

    function automatic rlts_pkg::t_out_item twinkle_predict(rlts_pkg::t_in_item it);
        rlts_pkg::t_out_item res;
        logic [LED_W-1:0]    led;
        logic [LED_W-1:0]    cur;
        logic [DATA_W:0]     span_end;
        res = '0;
        res.status = rlts_pkg::ST_WAIT;
        res.slot_out = it.slot;
        res.channel = CHAN_W'(it.slot) + rlts_pkg::CHANNEL_BASE;
        if (it.slot >= NUM_SLOTS) return res;
        if (it.func == rlts_pkg::FUNC_START) begin
            if (it.slot == 0) leds_free = ALL_LEDS;
            if (choose_free_led(it.rand_pick, led)) leds_free[led] = 1'b0;
            else led = '0;
            slot_begin[it.slot] = it.now_ms + delay_of(it.rand_offset);
            slot_len[it.slot] = '0;
            slot_owner[it.slot] = led;
            res.status = rlts_pkg::ST_START;
            res.old_led = led;
            res.new_led = led;
        end else begin
            cur = slot_owner[it.slot];
            span_end = {1'b0, slot_begin[it.slot]} + {1'b0, slot_len[it.slot]};
            res.old_led = cur;
            res.new_led = cur;
            if (slot_begin[it.slot] > it.now_ms) begin
                res.status = rlts_pkg::ST_WAIT;
            end else if (span_end < {1'b0, it.now_ms}) begin
                // With no LED free the slot keeps its LED, yet still gets new timing.
                if (choose_free_led(it.rand_pick, led)) begin
                    if (cur < NUM_LEDS) leds_free[cur] = 1'b1;
                    leds_free[led] = 1'b0;
                end else begin
                    led = cur;
                end
                slot_begin[it.slot] = it.now_ms + delay_of(it.rand_offset);
                slot_len[it.slot] = breathe_of(it.rand_period);
                slot_owner[it.slot] = led;
                res.status = rlts_pkg::ST_SWAP;
                res.new_led = led;
            end else begin
                res.status = rlts_pkg::ST_RUN;
            end
        end
        res.start_time = slot_begin[it.slot];
        res.period = slot_len[it.slot];
        return res;
    endfunction

    function automatic rlts_pkg::t_in_item twinkle_item(logic func, logic [SLOT_W-1:0] slot,
                                              logic [DATA_W-1:0] now, logic [DATA_W-1:0] roff,
                                              logic [DATA_W-1:0] rpick, logic [DATA_W-1:0] rper);
        rlts_pkg::t_in_item it;
        it.func = func;
        it.slot = slot;
        it.now_ms = now;
        it.rand_offset = roff;
        it.rand_pick = rpick;
        it.rand_period = rper;
        return it;
    endfunction

    // Picks a service time at or near the edges of the slot's waiting and running windows, inside them, or at random.
    function automatic logic [DATA_W-1:0] service_time(int unsigned s);
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] p;
        b = slot_begin[s];
        p = slot_len[s];
        case ($urandom_range(0, 9))
            0:       return b - 1 - $urandom_range(0, 50);
            1:       return b;
            2:       return b + p;
            3:       return b + p + 1;
            4:       return (p == '1) ? b + $urandom : b + $urandom % (p + 1);
            8:       return $urandom;
            9:       return b + $urandom_range(0, 3000);
            default: return b + p + 1 + $urandom_range(0, 5000);
        endcase
    endfunction

    function automatic string show(rlts_pkg::t_out_item r);
        return $sformatf("status=%0d slot=%0d old=%0d new=%0d ch=%0d start=%h period=%h",
                         r.status, r.slot_out, r.old_led, r.new_led, r.channel,
                         r.start_time, r.period);
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Each accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        rlts_pkg::t_out_item want;
        rlts_pkg::t_out_item got;
        string               diffs;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results_seen++;
            if (twinkle_expected.size() == 0) begin
                note_failure($sformatf("result with nothing outstanding: %s", show(got)));
            end else begin
                want = twinkle_expected.pop_front();
                status_seen[want.status]++;
                diffs = "";
                if (got.status !== want.status)         diffs = {diffs, " status"};
                if (got.slot_out !== want.slot_out)     diffs = {diffs, " slot_out"};
                if (got.old_led !== want.old_led)       diffs = {diffs, " old_led"};
                if (got.new_led !== want.new_led)       diffs = {diffs, " new_led"};
                if (got.channel !== want.channel)       diffs = {diffs, " channel"};
                if (got.start_time !== want.start_time) diffs = {diffs, " start_time"};
                if (got.period !== want.period)         diffs = {diffs, " period"};
                if (diffs != "")
                    note_failure($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                                           results_seen, diffs, show(want), show(got)));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, twinkle_expected.size());
            $display("** random_led_twinkle_scheduler_top: FAILED **");
            $finish;
        end
    end

    // Result side: changes its stall pattern at the end of each random-length segment, and on request
    // holds off for a long stretch.
    initial begin : result_sink
        t_rx_mode   mode;
        int         seg_left;
        int         k;
        logic [7:0] shape;
        mode = RX_ALWAYS;
        seg_left = 60;
        shape = 8'b1101_0110;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                for (k = 0; k < LONG_HOLD; k++) begin
                    out_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
                holds_done++;
            end
            if (seg_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                seg_left = $urandom_range(10, 150);
                shape = 8'($urandom);
            end
            seg_left--;
            case (mode)
                RX_ALWAYS: out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    out_ch.ready <= shape[0];
                    shape = {shape[0], shape[7:1]};
                end
            endcase
        end
    end

    // Offers one item and returns at the edge where the transaction takes place.
    task automatic send_item(rlts_pkg::t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        twinkle_expected = {twinkle_expected, twinkle_predict(it)};
        items_sent++;
        if (it.slot >= NUM_SLOTS) ignored_sent++;
    endtask

    task automatic idle_for(int unsigned n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (twinkle_expected.size() != 0);
    endtask

    task automatic start_slot(int unsigned s, logic [DATA_W-1:0] now,
                              logic [DATA_W-1:0] roff, logic [DATA_W-1:0] rpick);
        send_item(twinkle_item(rlts_pkg::FUNC_START, SLOT_W'(s), now, roff, rpick, $urandom));
        slot_armed[s] = 1'b1;
    endtask

    task automatic service_slot(int unsigned s, logic [DATA_W-1:0] now, logic [DATA_W-1:0] roff,
                                logic [DATA_W-1:0] rpick, logic [DATA_W-1:0] rper);
        send_item(twinkle_item(rlts_pkg::FUNC_SERVICE, SLOT_W'(s), now, roff, rpick, rper));
    endtask

    task automatic reg_check(rlts_pkg::t_reg_idx idx);
        logic [DATA_W-1:0] want;
        want = (idx == rlts_pkg::REG_START_OFFSET_MAX) ? offset_bound :
               (idx == rlts_pkg::REG_PERIOD_MIN)       ? period_floor : period_ceil;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            note_failure($sformatf("register %s reads %h, expected %h", idx.name(), prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(rlts_pkg::t_reg_idx idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            rlts_pkg::REG_START_OFFSET_MAX: offset_bound = value;
            rlts_pkg::REG_PERIOD_MIN:       period_floor = value;
            default:                        period_ceil = value;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        reg_check(idx);
    endtask

    task automatic test_settings(logic [DATA_W-1:0] off_max, logic [DATA_W-1:0] per_min,
                                 logic [DATA_W-1:0] per_max);
        wait_drained();
        reg_write(rlts_pkg::REG_START_OFFSET_MAX, off_max);
        reg_write(rlts_pkg::REG_PERIOD_MIN, per_min);
        reg_write(rlts_pkg::REG_PERIOD_MAX, per_max);
        settings_applied++;
    endtask

    task automatic test_register_reset_values();
        reg_check(rlts_pkg::REG_START_OFFSET_MAX);
        reg_check(rlts_pkg::REG_PERIOD_MIN);
        reg_check(rlts_pkg::REG_PERIOD_MAX);
    endtask

    task automatic test_directed_start_service();
        start_slot(0, '0, '0, '0);
        start_slot(1, '1, '1, '1);               // start time wraps past the top of the range
        start_slot(2, 32'd1000, 32'd1999, 32'd3);
        service_slot(0, '0, '0, '0, '0);         // now equals start plus zero period: running
        service_slot(2, 32'd1000, '0, '0, '0);   // start lies ahead: waiting
        service_slot(0, 32'd1, '1, '1, '1);
        service_slot(1, '0, '0, '0, '0);
        service_slot(1, '1, 32'h5555_5555, 32'hAAAA_AAAA, '0);
    endtask

    // Starts on slot 1 take LEDs without giving any back, so the mask runs dry.
    task automatic test_led_exhaustion();
        start_slot(0, 32'd5000, 32'd17, 32'd6);
        repeat (6) start_slot(1, 32'd5000, $urandom, $urandom);
        start_slot(2, 32'd6000, '0, $urandom);
        service_slot(1, slot_begin[1] + slot_len[1] + 1, $urandom, $urandom, $urandom);
        start_slot(0, 32'd7000, $urandom, $urandom);
        service_slot(2, slot_begin[2] + slot_len[2] + 1, $urandom, $urandom, $urandom);
    endtask

    task automatic test_ignored_slots();
        int unsigned s;
        for (s = NUM_SLOTS; s < 8; s++)
            send_item(twinkle_item(1'(s), SLOT_W'(s), '1, '1, '1, '1));
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned done;
        int unsigned burst_left;
        int unsigned roll;
        int unsigned s;
        done = 0;
        burst_left = 0;
        while (done < n_items) begin
            if (burst_left == 0) begin
                idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            s = $urandom_range(0, NUM_SLOTS - 1);
            if (roll < 5) begin
                send_item(twinkle_item(1'($urandom), SLOT_W'($urandom_range(NUM_SLOTS, 7)),
                                       $urandom, $urandom, $urandom, $urandom));
            end else begin
                if (roll < 10) s = 0;
                if (roll < 17 || !slot_armed[s])
                    start_slot(s, ($urandom_range(0, 1) != 0) ? $urandom
                                                              : $urandom_range(0, 100000),
                               $urandom, $urandom);
                else
                    service_slot(s, service_time(s), $urandom, $urandom, $urandom);
                done++;
            end
        end
    endtask

    // The result side holds off while items keep coming, so the input must stall.
    task automatic test_backpressure();
        int unsigned n;
        int unsigned s;
        wait_drained();
        holds_asked++;
        for (n = 0; n < 24; n++) begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            if (n % 5 == 0)
                start_slot(s, $urandom, $urandom, $urandom);
            else
                service_slot(s, service_time(s), $urandom, $urandom, $urandom);
        end
        wait_drained();
    endtask

    initial begin
        int unsigned i;
        int unsigned pmin;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        offset_bound = rlts_pkg::RST_START_OFFSET_MAX;
        period_floor = rlts_pkg::RST_PERIOD_MIN;
        period_ceil = rlts_pkg::RST_PERIOD_MAX;
        leds_free = ALL_LEDS;
        for (i = 0; i < NUM_SLOTS; i++) begin
            slot_begin[i] = '0;
            slot_len[i] = '0;
            slot_owner[i] = '0;
            slot_armed[i] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset_values();
        test_directed_start_service();
        test_led_exhaustion();
        test_ignored_slots();
        test_random_traffic(210);
        test_settings('0, '0, 32'd1);                    // zero delay bound, zero period
        test_random_traffic(230);
        test_settings(32'd1, 32'd100, 32'd50);           // empty period range
        test_random_traffic(230);
        test_settings('1, 32'hFFFF_FFFE, '1);            // widest values, end past 2^32
        test_random_traffic(230);
        test_settings(32'd7, 32'd3, 32'd20);
        test_random_traffic(230);
        pmin = $urandom_range(0, 1000);
        test_settings($urandom_range(1, 5000), pmin, pmin + $urandom_range(1, 4000));
        test_random_traffic(200);
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items (%0d to absent slots) under %0d register settings; %0d results.",
                 items_sent, ignored_sent, settings_applied + 1, results_seen);
        $display("Expected statuses: %0d waiting, %0d running, %0d swapped, %0d started; %0d errors.",
                 status_seen[rlts_pkg::ST_WAIT], status_seen[rlts_pkg::ST_RUN],
                 status_seen[rlts_pkg::ST_SWAP], status_seen[rlts_pkg::ST_START], mismatches);
        if (mismatches == 0 && twinkle_expected.size() == 0) begin
            $display("** random_led_twinkle_scheduler_top: PASSED **");
        end else begin
            $display("** random_led_twinkle_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rlts_pkg.sv
hw/rtl/rlts_stream_if.sv
hw/rtl/random_led_twinkle_scheduler_top.sv
bench/tb_top.sv
